>>> hw/rtl/qau_pkg.sv
`timescale 1ns / 1ps

package qau_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int FRACTION_BITS   = 12;

    localparam int CW = COMPONENT_WIDTH;
    localparam int F  = FRACTION_BITS;

    // square of one component, sum of four squares, signed product sum
    localparam int PROD_W = 2 * CW - 1;
    localparam int SUM_W  = 2 * CW + 1;
    localparam int ACC_W  = 2 * CW + 2;

    // divider: quotient bits, divisor width, dividend width
    localparam int Q_W   = 2 * F + 3;
    localparam int DEN_W = SUM_W + 1;
    localparam int NUM_W = PROD_W + 2 * F + 3;

    // square root: radicand must hold a quotient or four times the sum of squares
    localparam int SQ_IN_W = (Q_W > SUM_W + 2) ? Q_W : SUM_W + 2;
    localparam int ROOT_W  = (SQ_IN_W + 1) / 2;
    localparam int SQ_W    = 2 * ROOT_W;

    localparam int CLIP_W = (ACC_W > Q_W) ? ACC_W : Q_W;

    typedef enum logic [2:0] {
        CMD_MUL  = 3'd0,
        CMD_CONJ = 3'd1,
        CMD_INV  = 3'd2,
        CMD_NORM = 3'd3,
        CMD_NRMZ = 3'd4
    } cmd_t;

    typedef logic signed [CW-1:0] comp_t;

endpackage

>>> hw/rtl/qau_if.sv
`timescale 1ns / 1ps

interface qau_req_if;
    import qau_pkg::*;

    logic       valid;
    logic       ready;
    logic [2:0] command;
    comp_t      a_w;
    comp_t      a_x;
    comp_t      a_y;
    comp_t      a_z;
    comp_t      b_w;
    comp_t      b_x;
    comp_t      b_y;
    comp_t      b_z;

    modport source (
        output valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
        input  ready
    );

    modport sink (
        input  valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
        output ready
    );
endinterface

interface qau_rsp_if;
    import qau_pkg::*;

    logic  valid;
    logic  ready;
    comp_t r_w;
    comp_t r_x;
    comp_t r_y;
    comp_t r_z;
    logic  zero_norm;
    logic  saturated;

    modport source (
        output valid, r_w, r_x, r_y, r_z, zero_norm, saturated,
        input  ready
    );

    modport sink (
        input  valid, r_w, r_x, r_y, r_z, zero_norm, saturated,
        output ready
    );
endinterface

>>> hw/rtl/quaternion_arithmetic_unit.sv
`timescale 1ns / 1ps

// Quaternion arithmetic unit: multiply, conjugate, inverse, norm, normalize.
// request carries the command and quaternions a and b (signed Q3.12); b is
// read only by multiply. result returns r_w..r_z plus zero_norm and saturated.
// One result beat per request beat, in order.
// Pipeline: an accepted beat passes 4 front stages, Q_W = 27 divider stages,
// ROOT_W = 18 square-root stages and 1 output stage, the result register.
// Throughput: one beat per cycle while the result register is empty or being
// taken. Every stage shifts together; the depth is set by the restoring
// divider (one quotient bit per stage) and the square-root pipeline (one
// root bit per stage).
// When a valid result is not taken, the whole pipeline holds and request.ready drops;
// a waiting result does not block intake as long as the result register is
// empty or being taken. Nothing is dropped or repeated across a stall.
// Reset clears all valid bits; payload registers keep whatever they hold.
module quaternion_arithmetic_unit (
    input  logic      clk,
    input  logic      rst_n,
    qau_req_if.sink   request,
    qau_rsp_if.source result
);
    import qau_pkg::*;

    typedef struct packed {
        logic [CW-1:0] value;
        logic          sat;
    } clip_t;

    typedef struct packed {
        cmd_t               cmd;
        logic               zero;
        logic [3:0]         neg;
        logic [3:0][CW-1:0] early;
        logic               early_sat;
    } side_t;

    typedef struct packed {
        logic [3:0][DEN_W-1:0] rem;
        logic [3:0][Q_W-1:0]   low;
        logic [DEN_W-1:0]      den;
        logic [SQ_W-1:0]       root_in;
    } div_t;

    typedef struct packed {
        logic [3:0][SQ_W-1:0] n;
        logic [3:0][SQ_W-1:0] res;
        logic [3:0][Q_W-1:0]  quot;
    } sq_t;

    // Hamilton product terms: a index, b index, subtract
    localparam logic [1:0] A_IDX [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
        2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3
    };
    localparam logic [1:0] B_IDX [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2,
        2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0
    };
    localparam logic TERM_NEG [16] = '{
        1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0
    };

    function automatic clip_t clip(input logic neg, input logic [CLIP_W-1:0] mag);
        logic [CLIP_W-1:0] lim;
        clip_t             r;
        lim     = neg ? (CLIP_W'(1) << (CW - 1)) : ((CLIP_W'(1) << (CW - 1)) - CLIP_W'(1));
        r.sat   = mag > lim;
        r.value = r.sat ? lim[CW-1:0] : mag[CW-1:0];
        if (neg)
        begin
            r.value = -r.value;
        end
        return r;
    endfunction

    logic en;

    // stage 1: input capture
    logic                         s1_valid_reg;
    logic [2:0]                   s1_cmd_reg;
    comp_t                        s1_a_reg [4];
    comp_t                        s1_b_reg [4];

    // stage 2: products, squares, magnitudes
    logic                         s2_valid_reg;
    logic [2:0]                   s2_cmd_reg;
    logic signed [2*CW-1:0]       s2_prod_reg [16];
    logic signed [2*CW-1:0]       s2_prod_next [16];
    logic [PROD_W-1:0]            s2_sq_reg [4];
    logic [PROD_W-1:0]            s2_sq_next [4];
    logic [CW-1:0]                s2_am_reg [4];
    logic [CW-1:0]                s2_am_next [4];
    logic [3:0]                   s2_an_reg;
    logic [3:0]                   s2_an_next;

    // stage 3: sums
    logic                         s3_valid_reg;
    logic [2:0]                   s3_cmd_reg;
    logic signed [ACC_W-1:0]      s3_acc_reg [4];
    logic signed [ACC_W-1:0]      s3_acc_next [4];
    logic [SUM_W-1:0]             s3_s_reg;
    logic [SUM_W-1:0]             s3_s_next;
    logic [PROD_W-1:0]            s3_sq_reg [4];
    logic [CW-1:0]                s3_am_reg [4];
    logic [3:0]                   s3_an_reg;

    // stage 4: short results, divider operands
    logic                         pp_valid_reg;
    side_t                        pp_side_reg;
    side_t                        pp_side_next;
    div_t                         pp_div_reg;
    div_t                         pp_div_next;

    logic [Q_W-1:0]               dv_valid_reg;
    side_t                        dv_side_reg [Q_W];
    div_t                         dv_reg [Q_W];
    div_t                         dv_next [Q_W];

    sq_t                          sq_head;
    logic [ROOT_W-1:0]            sr_valid_reg;
    side_t                        sr_side_reg [ROOT_W];
    sq_t                          sr_reg [ROOT_W];
    sq_t                          sr_next [ROOT_W];

    logic                         out_valid_reg;
    logic [3:0][CW-1:0]           out_r_reg;
    logic [3:0][CW-1:0]           out_r_next;
    logic                         out_zn_reg;
    logic                         out_sat_reg;
    logic                         out_sat_next;

    assign en            = !out_valid_reg || result.ready;
    assign request.ready = en;

    // ---------------------------------------------------------------- valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            pp_valid_reg  <= 1'b0;
            dv_valid_reg  <= '0;
            sr_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= request.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            pp_valid_reg  <= s3_valid_reg;
            dv_valid_reg  <= {dv_valid_reg[Q_W-2:0], pp_valid_reg};
            sr_valid_reg  <= {sr_valid_reg[ROOT_W-2:0], dv_valid_reg[Q_W-1]};
            out_valid_reg <= sr_valid_reg[ROOT_W-1];
        end
    end

    // ---------------------------------------------------------------- stage 1
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cmd_reg  <= request.command;
            s1_a_reg[0] <= request.a_w;
            s1_a_reg[1] <= request.a_x;
            s1_a_reg[2] <= request.a_y;
            s1_a_reg[3] <= request.a_z;
            s1_b_reg[0] <= request.b_w;
            s1_b_reg[1] <= request.b_x;
            s1_b_reg[2] <= request.b_y;
            s1_b_reg[3] <= request.b_z;
        end
    end

    // ---------------------------------------------------------------- stage 2
    always_comb
    begin
        logic signed [2*CW-1:0] sqv;
        for (int k = 0; k < 16; k++)
        begin
            s2_prod_next[k] = s1_a_reg[A_IDX[k]] * s1_b_reg[B_IDX[k]];
        end
        for (int i = 0; i < 4; i++)
        begin
            sqv           = s1_a_reg[i] * s1_a_reg[i];
            s2_sq_next[i] = sqv[PROD_W-1:0];
            s2_an_next[i] = s1_a_reg[i][CW-1];
            // magnitude of the most negative value still fits unsigned
            s2_am_next[i] = s2_an_next[i] ? CW'(-s1_a_reg[i]) : CW'(s1_a_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_cmd_reg  <= s1_cmd_reg;
            s2_prod_reg <= s2_prod_next;
            s2_sq_reg   <= s2_sq_next;
            s2_am_reg   <= s2_am_next;
            s2_an_reg   <= s2_an_next;
        end
    end

    // ---------------------------------------------------------------- stage 3
    always_comb
    begin
        logic signed [ACC_W-1:0] term;
        s3_s_next = '0;
        for (int c = 0; c < 4; c++)
        begin
            s3_acc_next[c] = '0;
            for (int t = 0; t < 4; t++)
            begin
                term = ACC_W'(s2_prod_reg[4 * c + t]);
                if (TERM_NEG[4 * c + t])
                begin
                    s3_acc_next[c] = s3_acc_next[c] - term;
                end
                else
                begin
                    s3_acc_next[c] = s3_acc_next[c] + term;
                end
            end
            s3_s_next = s3_s_next + SUM_W'(s2_sq_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_cmd_reg <= s2_cmd_reg;
            s3_acc_reg <= s3_acc_next;
            s3_s_reg   <= s3_s_next;
            s3_sq_reg  <= s2_sq_reg;
            s3_am_reg  <= s2_am_reg;
            s3_an_reg  <= s2_an_reg;
        end
    end

    // ---------------------------------------------------------------- stage 4
    always_comb
    begin
        logic              neg_m;
        logic [ACC_W-1:0]  mag_m;
        logic [ACC_W-1:0]  rnd_m;
        clip_t             cm;
        clip_t             cc;
        logic [NUM_W-1:0]  num;
        pp_side_next      = '0;
        pp_div_next       = '0;
        pp_side_next.cmd  = cmd_t'(s3_cmd_reg);
        pp_side_next.zero = (s3_s_reg == '0)
                            && (s3_cmd_reg == CMD_INV || s3_cmd_reg == CMD_NRMZ);
        case (s3_cmd_reg)
            CMD_INV:  pp_div_next.den = DEN_W'(s3_s_reg) << 1;
            CMD_NRMZ: pp_div_next.den = DEN_W'(s3_s_reg);
            default:  pp_div_next.den = '0;
        endcase
        pp_div_next.root_in = SQ_W'(s3_s_reg) << 2;
        for (int i = 0; i < 4; i++)
        begin
            // product: round half away from zero on the magnitude
            neg_m = s3_acc_reg[i][ACC_W-1];
            mag_m = neg_m ? ACC_W'(-s3_acc_reg[i]) : ACC_W'(s3_acc_reg[i]);
            rnd_m = (mag_m + (ACC_W'(1) << (F - 1))) >> F;
            cm    = clip(neg_m, CLIP_W'(rnd_m));
            if (i == 0)
            begin
                cc = clip(s3_an_reg[i], CLIP_W'(s3_am_reg[i]));
            end
            else
            begin
                cc = clip(!s3_an_reg[i] && s3_am_reg[i] != '0, CLIP_W'(s3_am_reg[i]));
            end
            case (s3_cmd_reg)
                CMD_MUL:
                begin
                    pp_side_next.early[i]  = cm.value;
                    pp_side_next.early_sat = pp_side_next.early_sat | cm.sat;
                end
                CMD_CONJ:
                begin
                    pp_side_next.early[i]  = cc.value;
                    pp_side_next.early_sat = pp_side_next.early_sat | cc.sat;
                end
                default:
                begin
                    pp_side_next.early[i] = '0;
                end
            endcase
            pp_side_next.neg[i] = (s3_cmd_reg == CMD_INV && i != 0)
                                  ? !s3_an_reg[i] : s3_an_reg[i];
            // inverse: round(a * 2^2F / S) as floor((a*2^(2F+1) + S) / 2S)
            case (s3_cmd_reg)
                CMD_INV:  num = (NUM_W'(s3_am_reg[i]) << (2 * F + 1)) + NUM_W'(s3_s_reg);
                CMD_NRMZ: num = NUM_W'(s3_sq_reg[i]) << (2 * F + 2);
                default:  num = '0;
            endcase
            pp_div_next.rem[i] = DEN_W'(num >> Q_W);
            pp_div_next.low[i] = num[Q_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_side_reg <= pp_side_next;
            pp_div_reg  <= pp_div_next;
        end
    end

    // ---------------------------------------------------------------- divider
    // restoring division, one quotient bit per stage shifted into low
    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        div_t  d_in;
        side_t s_in;

        if (k == 0)
        begin : g_first
            assign d_in = pp_div_reg;
            assign s_in = pp_side_reg;
        end
        else
        begin : g_rest
            assign d_in = dv_reg[k-1];
            assign s_in = dv_side_reg[k-1];
        end

        always_comb
        begin
            logic [DEN_W:0] t;
            logic [DEN_W:0] diff;
            logic           ge;
            dv_next[k] = d_in;
            for (int i = 0; i < 4; i++)
            begin
                t                 = {d_in.rem[i], d_in.low[i][Q_W-1]};
                diff              = t - {1'b0, d_in.den};
                ge                = t >= {1'b0, d_in.den};
                dv_next[k].rem[i] = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
                dv_next[k].low[i] = {d_in.low[i][Q_W-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[k]      <= dv_next[k];
                dv_side_reg[k] <= s_in;
            end
        end
    end

    // ---------------------------------------------------------------- square root
    always_comb
    begin
        sq_head = '0;
        for (int i = 0; i < 4; i++)
        begin
            sq_head.quot[i] = dv_reg[Q_W-1].low[i];
            if (i == 0 && dv_side_reg[Q_W-1].cmd == CMD_NORM)
            begin
                sq_head.n[i] = dv_reg[Q_W-1].root_in;
            end
            else
            begin
                sq_head.n[i] = SQ_W'(dv_reg[Q_W-1].low[i]);
            end
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - k));
        sq_t   q_in;
        side_t s_in;

        if (k == 0)
        begin : g_first
            assign q_in = sq_head;
            assign s_in = dv_side_reg[Q_W-1];
        end
        else
        begin : g_rest
            assign q_in = sr_reg[k-1];
            assign s_in = sr_side_reg[k-1];
        end

        always_comb
        begin
            logic [SQ_W-1:0] t;
            sr_next[k] = q_in;
            for (int i = 0; i < 4; i++)
            begin
                t = q_in.res[i] + BIT;
                if (q_in.n[i] >= t)
                begin
                    sr_next[k].n[i]   = q_in.n[i] - t;
                    sr_next[k].res[i] = (q_in.res[i] >> 1) + BIT;
                end
                else
                begin
                    sr_next[k].res[i] = q_in.res[i] >> 1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sr_reg[k]      <= sr_next[k];
                sr_side_reg[k] <= s_in;
            end
        end
    end

    // ---------------------------------------------------------------- output stage
    side_t fin_side;
    sq_t   fin_q;

    assign fin_side = sr_side_reg[ROOT_W-1];
    assign fin_q    = sr_reg[ROOT_W-1];

    always_comb
    begin
        logic [ROOT_W-1:0] rnd [4];
        logic [ROOT_W:0]   inc;
        clip_t             cl;
        for (int i = 0; i < 4; i++)
        begin
            inc    = (ROOT_W + 1)'(fin_q.res[i][ROOT_W-1:0]) + (ROOT_W + 1)'(1);
            rnd[i] = inc[ROOT_W:1];
        end
        out_sat_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            case (fin_side.cmd)
                CMD_INV:
                begin
                    cl = clip(fin_side.neg[i] && fin_q.quot[i] != '0, CLIP_W'(fin_q.quot[i]));
                    out_r_next[i] = fin_side.zero ? '0 : cl.value;
                    out_sat_next  = out_sat_next | (cl.sat & !fin_side.zero);
                end
                CMD_NRMZ:
                begin
                    cl = clip(fin_side.neg[i] && rnd[i] != '0, CLIP_W'(rnd[i]));
                    out_r_next[i] = fin_side.zero ? '0 : cl.value;
                    out_sat_next  = out_sat_next | (cl.sat & !fin_side.zero);
                end
                CMD_NORM:
                begin
                    cl = clip(1'b0, CLIP_W'(rnd[0]));
                    out_r_next[i] = cl.value;
                    out_sat_next  = out_sat_next | cl.sat;
                end
                default:
                begin
                    cl            = '0;
                    out_r_next[i] = fin_side.early[i];
                    out_sat_next  = fin_side.early_sat;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_r_reg   <= out_r_next;
            out_zn_reg  <= fin_side.zero;
            out_sat_reg <= out_sat_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.r_w       = out_r_reg[0];
    assign result.r_x       = out_r_reg[1];
    assign result.r_y       = out_r_reg[2];
    assign result.r_z       = out_r_reg[3];
    assign result.zero_norm = out_zn_reg;
    assign result.saturated = out_sat_reg;

`ifndef SYNTHESIS
    // a stall freezes every stage's occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable({s1_valid_reg, s2_valid_reg, s3_valid_reg, pp_valid_reg,
                         dv_valid_reg, sr_valid_reg, out_valid_reg}))
        else $error("pipeline occupancy changed during stall");

    // zero quaternion gives an all-zero, unsaturated result
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.zero_norm) |->
            (!result.saturated && result.r_w == '0 && result.r_x == '0
             && result.r_y == '0 && result.r_z == '0))
        else $error("zero_norm result not cleared");

    // a unit quaternion never needs clipping
    assert property (@(posedge clk) disable iff (!rst_n)
        (sr_valid_reg[ROOT_W-1] && fin_side.cmd == CMD_NRMZ) |-> !out_sat_next)
        else $error("normalize result saturated");
`endif

endmodule

>>> tb/quaternion_arithmetic_unit_tb.sv
`timescale 1ns / 1ps

module quaternion_arithmetic_unit_tb;
    import qau_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int TAIL_ITEMS   = 120;
    localparam int LATENCY      = 50;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 150;

    typedef struct {
        comp_t r[4];
        bit    zn;
        bit    sat;
    } quat_result_t;

    typedef struct {
        logic [2:0]   cmd;
        comp_t        a[4];
        comp_t        b[4];
        bit           typed;
        quat_result_t res;
    } stim_row_t;

    logic clk;
    logic rst_n;

    qau_req_if request ();
    qau_rsp_if result ();

    quaternion_arithmetic_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .result  (result)
    );

    quat_result_t pending_results[$];
    int errors;
    int sent;
    int received;
    int cycles;
    int cmd_seen[8];
    bit sending_done;
    bit hold_done;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t beat %0d: %s", $time, received, msg);
        errors++;
    endtask

    function automatic bit [63:0] isqrt64(input bit [63:0] n);
        bit [63:0] root;
        bit [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // sign plus magnitude onto the component range
    function automatic comp_t clamp(input bit neg, input bit [63:0] mag, inout bit sat);
        bit [63:0] lim;
        bit [63:0] m;
        lim = neg ? 64'd32768 : 64'd32767;
        m = mag;
        if (mag > lim)
        begin
            m = lim;
            sat = 1'b1;
        end
        return neg ? comp_t'(-m) : comp_t'(m);
    endfunction

    function automatic quat_result_t quat_compute(input logic [2:0] cmd,
                                                  input comp_t a[4], input comp_t b[4]);
        quat_result_t res;
        longint       av[4];
        longint       bv[4];
        longint       acc[4];
        bit [63:0]    mag[4];
        bit [63:0]    s;
        bit [63:0]    q;
        bit [63:0]    n;
        bit           neg;
        s = 0;
        res.zn = 0;
        res.sat = 0;
        for (int i = 0; i < 4; i++)
        begin
            av[i] = longint'(a[i]);
            bv[i] = longint'(b[i]);
            mag[i] = av[i] < 0 ? -av[i] : av[i];
            s += mag[i] * mag[i];
            res.r[i] = '0;
        end
        case (cmd)
            CMD_MUL:
            begin
                acc[0] = av[0]*bv[0] - av[1]*bv[1] - av[2]*bv[2] - av[3]*bv[3];
                acc[1] = av[0]*bv[1] + av[1]*bv[0] + av[2]*bv[3] - av[3]*bv[2];
                acc[2] = av[0]*bv[2] - av[1]*bv[3] + av[2]*bv[0] + av[3]*bv[1];
                acc[3] = av[0]*bv[3] + av[1]*bv[2] - av[2]*bv[1] + av[3]*bv[0];
                for (int i = 0; i < 4; i++)
                begin
                    neg = acc[i] < 0;
                    q = neg ? -acc[i] : acc[i];
                    q = (q + (64'd1 << (F - 1))) >> F;
                    res.r[i] = clamp(neg, q, res.sat);
                end
            end
            CMD_CONJ:
                for (int i = 0; i < 4; i++)
                    res.r[i] = clamp(i == 0 ? av[i] < 0 : av[i] > 0, mag[i], res.sat);
            CMD_INV, CMD_NRMZ:
                if (s == 0)
                    res.zn = 1'b1;
                else
                    for (int i = 0; i < 4; i++)
                    begin
                        if (cmd == CMD_INV)
                        begin
                            q = ((mag[i] << (2 * F + 1)) + s) / (s << 1);
                            neg = (i == 0) ? av[i] < 0 : av[i] >= 0;
                        end
                        else
                        begin
                            q = (isqrt64(((mag[i] * mag[i]) << (2 * F + 2)) / s) + 1) >> 1;
                            neg = av[i] < 0;
                        end
                        res.r[i] = clamp(neg && q != 0, q, res.sat);
                    end
            CMD_NORM:
            begin
                n = (isqrt64(s << 2) + 1) >> 1;
                res.r[0] = clamp(1'b0, n, res.sat);
                for (int i = 1; i < 4; i++)
                    res.r[i] = res.r[0];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic stim_row_t row(input logic [2:0] cmd,
                                      input int aw, ax, ay, az, bw, bx, by, bz,
                                      input bit typed = 0,
                                      input int rw = 0, rx = 0, ry = 0, rz = 0,
                                      input bit zn = 0, sat = 0);
        stim_row_t t;
        t.cmd = cmd;
        t.a[0] = comp_t'(aw); t.a[1] = comp_t'(ax);
        t.a[2] = comp_t'(ay); t.a[3] = comp_t'(az);
        t.b[0] = comp_t'(bw); t.b[1] = comp_t'(bx);
        t.b[2] = comp_t'(by); t.b[3] = comp_t'(bz);
        t.typed = typed;
        t.res.r[0] = comp_t'(rw); t.res.r[1] = comp_t'(rx);
        t.res.r[2] = comp_t'(ry); t.res.r[3] = comp_t'(rz);
        t.res.zn = zn;
        t.res.sat = sat;
        return t;
    endfunction

    function automatic comp_t rand_comp();
        case ($urandom_range(0, 5))
            0:       return comp_t'($urandom());
            1:       return '0;
            2:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return comp_t'($urandom_range(0, 16384) - 8192);
        endcase
    endfunction

    task automatic send_beat(input stim_row_t t);
        quat_result_t res;
        request.valid   <= 1'b1;
        request.command <= t.cmd;
        request.a_w <= t.a[0]; request.a_x <= t.a[1];
        request.a_y <= t.a[2]; request.a_z <= t.a[3];
        request.b_w <= t.b[0]; request.b_x <= t.b[1];
        request.b_y <= t.b[2]; request.b_z <= t.b[3];
        @(posedge clk);
        while (!request.ready)
            @(posedge clk);
        if (t.typed)
            res = t.res;
        else
            res = quat_compute(t.cmd, t.a, t.b);
        pending_results.push_back(res);
        cmd_seen[t.cmd]++;
        sent++;
        // idle bursts, none near the end
        if (sent < RANDOM_ITEMS - TAIL_ITEMS && $urandom_range(0, 3) == 0)
        begin
            request.valid <= 1'b0;
            repeat ($urandom_range(1, 13))
                @(posedge clk);
        end
    endtask

    initial
    begin
        stim_row_t directed[$];
        stim_row_t t;
        request.valid = 1'b0;
        request.command = '0;
        {request.a_w, request.a_x, request.a_y, request.a_z} = '0;
        {request.b_w, request.b_x, request.b_y, request.b_z} = '0;
        rst_n = 1'b0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(row(CMD_INV,  0, 0, 0, 0, 5, 5, 5, 5, 1, 0, 0, 0, 0, 1, 0));
        directed.push_back(row(CMD_NRMZ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0));
        directed.push_back(row(CMD_NORM, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(3'd5, 100, 2, 3, 4, 5, 6, 7, 8, 1));
        directed.push_back(row(3'd6, -1, -1, -1, -1, -1, -1, -1, -1, 1));
        directed.push_back(row(3'd7, 32767, -32768, 1, 1, 1, 1, 1, 1, 1));
        directed.push_back(row(CMD_CONJ, -32768, -32768, 32767, 0, 0, 0, 0, 0,
                               1, -32768, 32767, -32767, 0, 0, 1));
        directed.push_back(row(CMD_CONJ, 4096, 4096, -4096, 0, 0, 0, 0, 0,
                               1, 4096, -4096, 4096, 0, 0, 0));
        directed.push_back(row(CMD_MUL, 4096, 0, 0, 0, 1234, -567, 89, -32768,
                               1, 1234, -567, 89, -32768, 0, 0));
        directed.push_back(row(CMD_MUL, 32767, 32767, 32767, 32767,
                               32767, 32767, 32767, 32767));
        directed.push_back(row(CMD_MUL, -32768, -32768, -32768, -32768,
                               -32768, 32767, -32768, 32767));
        directed.push_back(row(CMD_MUL, 0, 4096, 0, 0, 0, 4096, 0, 0,
                               1, -4096, 0, 0, 0, 0, 0));
        directed.push_back(row(CMD_INV, 4096, 0, 0, 0, 0, 0, 0, 0, 1, 4096, 0, 0, 0, 0, 0));
        directed.push_back(row(CMD_INV, 1, 0, 0, 0, 0, 0, 0, 0, 1, 32767, 0, 0, 0, 0, 1));
        directed.push_back(row(CMD_INV, -32768, -32768, -32768, -32768, 0, 0, 0, 0));
        directed.push_back(row(CMD_INV, 1000, -2000, 3000, -4000, 0, 0, 0, 0));
        directed.push_back(row(CMD_NORM, -32768, -32768, -32768, -32768, 0, 0, 0, 0,
                               1, 32767, 32767, 32767, 32767, 0, 1));
        directed.push_back(row(CMD_NORM, 3, 4, 0, 0, 0, 0, 0, 0, 1, 5, 5, 5, 5, 0, 0));
        directed.push_back(row(CMD_NORM, 32767, 1, -1, 7, 0, 0, 0, 0));
        directed.push_back(row(CMD_NRMZ, -32768, 0, 0, 0, 0, 0, 0, 0,
                               1, -4096, 0, 0, 0, 0, 0));
        directed.push_back(row(CMD_NRMZ, 1, 1, 1, 1, 0, 0, 0, 0));
        directed.push_back(row(CMD_NRMZ, 32767, -32768, 12345, -1, 0, 0, 0, 0));
        directed.push_back(row(CMD_NRMZ, 0, 0, 0, -1, 0, 0, 0, 0, 1, 0, 0, 0, -4096, 0, 0));

        foreach (directed[i])
            send_beat(directed[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            t.cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
            for (int i = 0; i < 4; i++)
            begin
                t.a[i] = rand_comp();
                t.b[i] = rand_comp();
            end
            t.typed = 0;
            send_beat(t);
        end
        request.valid <= 1'b0;
        sending_done = 1;
    end

    // result side: random stalls, one long hold to back the pipeline up
    initial
    begin
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && sent >= 200)
            begin
                result.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_done = 1;
                result.ready <= 1'b1;
            end
            else if (sent < RANDOM_ITEMS - TAIL_ITEMS && $urandom_range(0, 4) == 0)
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 13))
                    @(posedge clk);
                result.ready <= 1'b1;
            end
            else
                result.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        quat_result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                want = pending_results.pop_front();
                if (result.r_w !== want.r[0])
                    report_mismatch($sformatf("r_w %0d exp %0d", result.r_w, want.r[0]));
                if (result.r_x !== want.r[1])
                    report_mismatch($sformatf("r_x %0d exp %0d", result.r_x, want.r[1]));
                if (result.r_y !== want.r[2])
                    report_mismatch($sformatf("r_y %0d exp %0d", result.r_y, want.r[2]));
                if (result.r_z !== want.r[3])
                    report_mismatch($sformatf("r_z %0d exp %0d", result.r_z, want.r[3]));
                if (result.zero_norm !== want.zn)
                    report_mismatch($sformatf("zero_norm %b exp %b", result.zero_norm, want.zn));
                if (result.saturated !== want.sat)
                    report_mismatch($sformatf("saturated %b exp %b", result.saturated, want.sat));
            end
            received++;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        wait (sending_done);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10)
            @(posedge clk);
        $display("Sent %0d beats, checked %0d results; mul %0d conj %0d inv %0d norm %0d",
                 sent, received, cmd_seen[CMD_MUL], cmd_seen[CMD_CONJ],
                 cmd_seen[CMD_INV], cmd_seen[CMD_NORM]);
        $display("normalize %0d, unused commands %0d, long output hold %0d cycles",
                 cmd_seen[CMD_NRMZ], cmd_seen[5] + cmd_seen[6] + cmd_seen[7], HOLD_CYCLES);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/qau_pkg.sv
hw/rtl/qau_if.sv
hw/rtl/quaternion_arithmetic_unit.sv
tb/quaternion_arithmetic_unit_tb.sv
